// ===== design/tagged_byte_stack_macros.svh =====
// assertion macros for the tagged byte stack
`ifndef TAGGED_BYTE_STACK_MACROS_SVH
`define TAGGED_BYTE_STACK_MACROS_SVH

// implication checked on every clock edge outside reset
`define TBS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define TBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/tbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbs_pkg
// shared constants and types of the tagged byte stack
// ----------------------------------------------------------------------------
package tbs_pkg;

   localparam int STACK_DEPTH_DEF = 256;
   localparam int MAX_STRING_DEF  = 64;
   localparam int TAG_CHAR_DEF    = 1;
   localparam int TAG_INT_DEF     = 2;
   localparam int TAG_FLOAT_DEF   = 3;
   localparam int TAG_STRING_DEF  = 4;

   typedef enum logic [3:0] {
      K_PUSH_BYTE  = 4'd0,
      K_PUSH_CHAR  = 4'd1,
      K_PUSH_INT   = 4'd2,
      K_PUSH_FLOAT = 4'd3,
      K_PUSH_STR   = 4'd4,
      K_POP_BYTE   = 4'd5,
      K_POP_CHAR   = 4'd6,
      K_POP_INT    = 4'd7,
      K_POP_FLOAT  = 4'd8,
      K_POP_STR    = 4'd9,
      K_POP_ANY    = 4'd10,
      K_PEEK_BYTE  = 4'd11,
      K_PEEK_CHAR  = 4'd12,
      K_PEEK_INT   = 4'd13,
      K_PEEK_FLOAT = 4'd14,
      K_PEEK_ANY   = 4'd15
   } kind_type;

   localparam logic [2:0] VT_NONE  = 3'd0;
   localparam logic [2:0] VT_BYTE  = 3'd1;
   localparam logic [2:0] VT_CHAR  = 3'd2;
   localparam logic [2:0] VT_INT   = 3'd3;
   localparam logic [2:0] VT_FLOAT = 3'd4;
   localparam logic [2:0] VT_STRB  = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // memory port request from sequencer to ram
   typedef struct packed {
      logic        wr;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } mem_req_type;

endpackage

// ===== design/tbs_ram.sv =====
// ----------------------------------------------------------------------------
// tbs_ram
// byte-wide single-port stack memory with registered read
// ----------------------------------------------------------------------------
module tbs_ram
   import tbs_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int AW = $clog2(STACK_DEPTH)
) (
   input  logic        clock,
   input  mem_req_type req,
   output logic [7:0]  rdata
);

   logic [7:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.addr[AW-1:0]] <= req.wdata;
      end
      rdata <= mem[req.addr[AW-1:0]];
   end

endmodule

// ===== design/tagged_byte_stack.sv =====
// ----------------------------------------------------------------------------
// tagged_byte_stack
// byte-wide typed operand stack with a byte-serial sequencer
// ----------------------------------------------------------------------------
// One word is taken at a time; the block drops ready while it works. Each
// word walks the single byte port of the stack memory, one byte at a time.
// A memory read passes three states (address, wait, gather). A push writes
// its stored bytes in turn, a byte pop or peek reads one byte, a typed pop
// or peek reads the tag and then the payload, and a string pop reads the
// tag, the length and then each string byte (each string byte also waits
// for its result to be moved). A word that cuts off a partial string passes
// the decode state once more. The result is held in an output register, and
// the next word is taken as soon as the last result has been moved. The
// memory needs no clearing: no read reaches a byte never written.
module tagged_byte_stack
   import tbs_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int MAX_STRING  = MAX_STRING_DEF,
   parameter int TAG_CHAR    = TAG_CHAR_DEF,
   parameter int TAG_INT     = TAG_INT_DEF,
   parameter int TAG_FLOAT   = TAG_FLOAT_DEF,
   parameter int TAG_STRING  = TAG_STRING_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[3:0], value[35:4], offset[43:36], string_length[50:44], pad
   input  logic [55:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // data[31:0], value_type[34:32], status[36:35], pad
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int PW = $clog2(STACK_DEPTH + 1);
   localparam logic [7:0] TC = 8'(TAG_CHAR);
   localparam logic [7:0] TI = 8'(TAG_INT);
   localparam logic [7:0] TF = 8'(TAG_FLOAT);
   localparam logic [7:0] TS = 8'(TAG_STRING);
   localparam logic [PW+7:0] DEP = (PW+8)'(STACK_DEPTH);
   localparam logic [6:0] MAXS = 7'(MAX_STRING);

   typedef enum logic [3:0] {
      S_IDLE, S_DEC, S_PUSH, S_RD, S_RWAIT, S_GATHER, S_SLEN, S_STR, S_OUT
   } state_type;

   state_type     state_ff, state_in;
   kind_type      kind_ff, kind_in;
   logic [31:0]   val_ff, val_in;
   logic [7:0]    off_ff, off_in;
   logic [6:0]    slen_ff, slen_in;
   logic          fin_ff, fin_in;
   logic [PW-1:0] sp_ff, sp_in;
   logic          sip_ff, sip_in, srej_ff, srej_in;
   logic [6:0]    scnt_ff, scnt_in;
   logic [2:0]    bcnt_ff, bcnt_in;   // bytes left in current burst
   logic [2:0]    want_ff, want_in;
   logic [31:0]   acc_ff, acc_in;
   logic [6:0]    len_ff, len_in, idx_ff, idx_in;
   logic          ov_ff, ov_in;
   logic [31:0]   od_ff, od_in;
   logic [2:0]    ovt_ff, ovt_in;
   logic [1:0]    ost_ff, ost_in;
   logic          olast_ff, olast_in;
   logic [39:0]   pbuf_ff, pbuf_in;   // push bytes, first out in [7:0]
   logic [PW-1:0] raddr_ff, raddr_in; // depth being read
   mem_req_type   mreq;
   logic [7:0]    rdata;

   tbs_ram #(.STACK_DEPTH(STACK_DEPTH)) u_ram (
      .clock(clock), .req(mreq), .rdata(rdata)
   );

   assign req_tready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {3'b0, ost_ff, ovt_ff, od_ff};
   assign rsp_tlast  = olast_ff;

   always_comb begin
      logic [PW+7:0] spw;
      logic [PW-1:0] spa;
      logic          do_out;
      state_in = state_ff; kind_in = kind_ff; val_in = val_ff; off_in = off_ff;
      slen_in = slen_ff; fin_in = fin_ff; sp_in = sp_ff; sip_in = sip_ff;
      srej_in = srej_ff; scnt_in = scnt_ff; bcnt_in = bcnt_ff; want_in = want_ff;
      acc_in = acc_ff; len_in = len_ff; idx_in = idx_ff; ov_in = ov_ff;
      od_in = od_ff; ovt_in = ovt_ff; ost_in = ost_ff; olast_in = olast_ff;
      pbuf_in = pbuf_ff; raddr_in = raddr_ff;
      mreq = '0;
      do_out = 1'b0;
      spw = (PW+8)'(sp_ff);
      spa = sp_ff;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !ov_ff) begin
               kind_in = kind_type'(req_tdata[3:0]);
               val_in  = req_tdata[35:4];
               off_in  = req_tdata[43:36];
               slen_in = req_tdata[50:44];
               fin_in  = req_tlast;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            // abort a partial string unless this is another string byte
            if (kind_ff != K_PUSH_STR && sip_ff) begin
               if (!srej_ff && PW'(scnt_ff) <= sp_ff) sp_in = sp_ff - PW'(scnt_ff);
               sip_in = 1'b0; srej_in = 1'b0; scnt_in = '0;
               state_in = S_DEC;
            end else begin
               od_in = '0; ovt_in = VT_NONE; ost_in = ST_OK; olast_in = 1'b1;
               case (kind_ff)
                  K_PUSH_BYTE, K_PUSH_CHAR, K_PUSH_INT, K_PUSH_FLOAT: begin
                     logic [2:0] n;
                     case (kind_ff)
                        K_PUSH_BYTE: begin n = 3'd1; pbuf_in = {32'b0, val_ff[7:0]}; end
                        K_PUSH_CHAR: begin n = 3'd2; pbuf_in = {24'b0, TC, val_ff[7:0]}; end
                        K_PUSH_INT: begin
                           n = 3'd3; pbuf_in = {16'b0, TI, val_ff[7:0], val_ff[15:8]};
                        end
                        default: begin
                           n = 3'd5;
                           pbuf_in = {TF, val_ff[7:0], val_ff[15:8], val_ff[23:16],
                                      val_ff[31:24]};
                        end
                     endcase
                     if (spw + (PW+8)'(n) > DEP) begin
                        ost_in = ST_FULL; do_out = 1'b1;
                     end else begin
                        bcnt_in = n; state_in = S_PUSH;
                     end
                  end
                  K_PUSH_STR: begin
                     logic rej;
                     logic [6:0] cnt;
                     rej = srej_ff; cnt = scnt_ff;
                     if (!sip_ff) begin
                        cnt = '0;
                        rej = slen_ff == 7'd0 || slen_ff > MAXS ||
                              spw + (PW+8)'(slen_ff) + (PW+8)'(3) > DEP;
                     end
                     if (!rej && spw + (PW+8)'(3) > DEP) begin
                        if (PW'(cnt) <= sp_ff) spa = sp_ff - PW'(cnt);
                        rej = 1'b1;
                     end
                     cnt = cnt + 7'd1;
                     if (rej) ost_in = ST_FULL;
                     if (fin_ff || cnt >= MAXS) begin
                        sip_in = 1'b0; srej_in = 1'b0; scnt_in = '0;
                        if (!rej) begin
                           pbuf_in = {16'b0, TS, 1'b0, cnt, val_ff[7:0]};
                           bcnt_in = 3'd3; state_in = S_PUSH;
                        end else do_out = 1'b1;
                     end else begin
                        sip_in = 1'b1; srej_in = rej; scnt_in = cnt;
                        if (!rej) begin
                           pbuf_in = {32'b0, val_ff[7:0]};
                           bcnt_in = 3'd1; state_in = S_PUSH;
                        end else do_out = 1'b1;
                     end
                     sp_in = spa;
                  end
                  K_POP_BYTE, K_PEEK_BYTE: begin
                     logic [PW-1:0] d;
                     d = (kind_ff == K_PEEK_BYTE) ? PW'(off_ff) : '0;
                     if ((PW+8)'(off_ff) >= spw && kind_ff == K_PEEK_BYTE || sp_ff == '0) begin
                        ost_in = ST_EMPTY; do_out = 1'b1;
                     end else begin
                        want_in = VT_BYTE; bcnt_in = 3'd1; raddr_in = d;
                        acc_in = '0; state_in = S_RD;
                     end
                  end
                  default: begin
                     // read the tag first
                     if (sp_ff == '0) begin
                        ost_in = ST_EMPTY; do_out = 1'b1;
                     end else begin
                        want_in = VT_NONE; bcnt_in = 3'd1; raddr_in = '0;
                        acc_in = '0; state_in = S_RD;
                     end
                  end
               endcase
            end
         end
         S_PUSH: begin
            mreq.wr = 1'b1; mreq.addr = 16'(sp_ff); mreq.wdata = pbuf_ff[7:0];
            pbuf_in = pbuf_ff >> 8;
            sp_in = sp_ff + PW'(1);
            bcnt_in = bcnt_ff - 3'd1;
            if (bcnt_ff == 3'd1) do_out = 1'b1;
         end
         S_RD: begin
            mreq.addr = 16'(sp_ff - PW'(1) - raddr_ff);
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            // keep the address so the read data stays put
            mreq.addr = 16'(sp_ff - PW'(1) - raddr_ff);
            state_in = S_GATHER;
         end
         S_GATHER: begin
            mreq.addr = 16'(sp_ff - PW'(1) - raddr_ff);
            if (want_ff == VT_NONE) begin
               // rdata is the tag: pick the kind and check size
               logic [2:0] vt;
               logic [2:0] need;
               vt = VT_NONE; need = 3'd0;
               case (kind_ff)
                  K_POP_CHAR, K_PEEK_CHAR: vt = (rdata == TC) ? VT_CHAR : VT_NONE;
                  K_POP_INT, K_PEEK_INT: vt = (rdata == TI) ? VT_INT : VT_NONE;
                  K_POP_FLOAT, K_PEEK_FLOAT: vt = (rdata == TF) ? VT_FLOAT : VT_NONE;
                  K_POP_STR: vt = (rdata == TS) ? VT_STRB : VT_NONE;
                  default: begin
                     if (rdata == TC) vt = VT_CHAR;
                     else if (rdata == TI) vt = VT_INT;
                     else if (rdata == TF) vt = VT_FLOAT;
                  end
               endcase
               case (vt)
                  VT_CHAR: need = 3'd2;
                  VT_INT: need = 3'd3;
                  VT_FLOAT: need = 3'd5;
                  VT_STRB: need = 3'd3;
                  default: need = 3'd0;
               endcase
               if (vt == VT_NONE || spw < (PW+8)'(need)) begin
                  ost_in = ST_EMPTY; do_out = 1'b1;
               end else begin
                  want_in = vt; raddr_in = PW'(1); state_in = S_RD;
                  bcnt_in = need - 3'd1;
                  if (vt == VT_STRB) state_in = S_RD;
               end
            end else if (want_ff == VT_STRB && len_ff == 7'd0 && idx_ff == 7'd0) begin
               state_in = S_SLEN;
            end else if (want_ff == VT_STRB) begin
               od_in = {24'b0, rdata}; ovt_in = VT_STRB; ost_in = ST_OK;
               olast_in = (idx_ff == 7'd1);
               ov_in = 1'b1;
               state_in = S_STR;
            end else begin
               acc_in = {acc_ff[23:0], rdata};
               bcnt_in = bcnt_ff - 3'd1;
               if (bcnt_ff == 3'd1 || want_ff == VT_BYTE) begin
                  od_in = (want_ff == VT_BYTE) ? {24'b0, rdata}
                        : {acc_ff[23:0], rdata};
                  ovt_in = want_ff; ost_in = ST_OK; olast_in = 1'b1;
                  if (kind_ff == K_POP_BYTE) sp_in = sp_ff - PW'(1);
                  else if (kind_ff <= K_POP_ANY)
                     sp_in = sp_ff - ((want_ff == VT_CHAR) ? PW'(2) :
                                      (want_ff == VT_INT) ? PW'(3) : PW'(5));
                  do_out = 1'b1;
               end else begin
                  // ints and floats are read from the deepest byte upward
                  raddr_in = raddr_ff - PW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_SLEN: begin
            // rdata is the stored length
            if (rdata == 8'd0 || rdata > 8'(MAXS) ||
                (PW+8)'(rdata) > spw - (PW+8)'(2)) begin
               ost_in = ST_EMPTY; ovt_in = VT_NONE; od_in = '0; olast_in = 1'b1;
               do_out = 1'b1;
            end else begin
               len_in = rdata[6:0]; idx_in = rdata[6:0];
               raddr_in = PW'(rdata) + PW'(1);
               state_in = S_RD;
            end
         end
         S_STR: begin
            if (!ov_ff || rsp_tready) begin
               if (idx_ff == 7'd1) begin
                  sp_in = sp_ff - PW'(len_ff) - PW'(2);
                  len_in = '0; idx_in = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff - 7'd1;
                  raddr_in = raddr_ff - PW'(1);
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // the int and float gather start at the deepest payload byte
      if (state_ff == S_GATHER && want_ff == VT_NONE && state_in == S_RD &&
          want_in != VT_STRB) raddr_in = PW'(bcnt_in);
      if (state_ff == S_GATHER && want_ff == VT_NONE && state_in == S_RD &&
          want_in == VT_STRB) begin
         raddr_in = PW'(1); len_in = '0; idx_in = '0;
      end
      if (do_out) begin
         ov_in = 1'b1; state_in = S_IDLE;
         if (state_ff != S_GATHER && ost_in != ST_OK) begin
            od_in = '0; ovt_in = VT_NONE;
         end
      end
   end

   // gather reads bytes downward in depth for ints/floats
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; sp_ff <= '0; sip_ff <= 1'b0; srej_ff <= 1'b0;
         scnt_ff <= '0; ov_ff <= 1'b0; len_ff <= '0; idx_ff <= '0;
      end else begin
         state_ff <= state_in; sp_ff <= sp_in; sip_ff <= sip_in; srej_ff <= srej_in;
         scnt_ff <= scnt_in; ov_ff <= ov_in; len_ff <= len_in; idx_ff <= idx_in;
      end
      kind_ff <= kind_in; val_ff <= val_in; off_ff <= off_in; slen_ff <= slen_in;
      fin_ff <= fin_in; bcnt_ff <= bcnt_in; want_ff <= want_in; acc_ff <= acc_in;
      od_ff <= od_in; ovt_ff <= ovt_in; ost_ff <= ost_in; olast_ff <= olast_in;
      pbuf_ff <= pbuf_in; raddr_ff <= raddr_in;
   end

endmodule

// ===== design/tbs_checker.sv =====
// ----------------------------------------------------------------------------
// tbs_checker
// port-level checks of the tagged byte stack
// ----------------------------------------------------------------------------
`include "tagged_byte_stack_macros.svh"

module tbs_checker
   import tbs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   `TBS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready)
   `TBS_ASSERT_IMP(a_no_take_while_out, clock, reset, rsp_tvalid, !req_tready)
   `TBS_ASSERT_IMP(a_fail_zero, clock, reset, rsp_tvalid && rsp_tdata[36:35] != ST_OK,
      rsp_tdata[31:0] == 32'd0 && rsp_tdata[34:32] == VT_NONE && rsp_tlast)
   `TBS_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

endmodule

bind tagged_byte_stack tbs_checker u_tbs_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);

// ===== tb/tagged_byte_stack_checker.sv =====
// ----------------------------------------------------------------------------
// tagged_byte_stack_checker
// watches both channels, models the typed stack and compares every response
// ----------------------------------------------------------------------------
module tagged_byte_stack_checker
   import tbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam int MAXS  = MAX_STRING_DEF;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  vtype;
      logic [1:0]  status;
      logic        last;
   } rsp_word_type;

   logic [7:0]   bytes_q [DEPTH];
   int           sp;
   bit           str_busy;
   bit           str_bad;
   int           str_cnt;
   rsp_word_type expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic logic [7:0] byte_at(int d);
      return bytes_q[sp - 1 - d];
   endfunction

   function automatic void push_byte(logic [7:0] b);
      if (sp < DEPTH) begin
         bytes_q[sp] = b;
         sp++;
      end
   endfunction

   function automatic void add_rsp(logic [31:0] d, logic [2:0] vt, logic [1:0] st,
                                   logic l);
      rsp_word_type r;
      r.data = d; r.vtype = vt; r.status = st; r.last = l;
      expected_rsp.push_back(r);
   endfunction

   function automatic void clear_string();
      str_busy = 0; str_bad = 0; str_cnt = 0;
   endfunction

   // model of one accepted request word
   function automatic void predict_stack(kind_type k, logic [31:0] v, logic [7:0] off,
                                         logic [6:0] slen, logic fin);
      logic [7:0]  want_tag;
      logic [2:0]  vt;
      int          need;
      logic [31:0] d;
      int          len;
      if (k == K_PUSH_STR) begin
         if (!str_busy) begin
            str_busy = 1; str_cnt = 0;
            str_bad = slen == 0 || slen > MAXS || sp + slen + 3 > DEPTH;
         end
         // not enough room for this byte plus length and tag
         if (!str_bad && sp + 3 > DEPTH) begin
            if (str_cnt <= sp) sp -= str_cnt;
            str_bad = 1;
         end
         if (!str_bad) push_byte(v[7:0]);
         str_cnt++;
         add_rsp(0, VT_NONE, str_bad ? ST_FULL : ST_OK, 1);
         if (fin || str_cnt >= MAXS) begin
            if (!str_bad) begin
               push_byte(str_cnt[7:0]);
               push_byte(TAG_STRING_DEF[7:0]);
            end
            clear_string();
         end
         return;
      end
      // any other word drops a partial string
      if (str_busy) begin
         if (!str_bad && str_cnt <= sp) sp -= str_cnt;
         clear_string();
      end
      case (k)
         K_PUSH_BYTE, K_PUSH_CHAR, K_PUSH_INT, K_PUSH_FLOAT: begin
            need = (k == K_PUSH_BYTE) ? 1 : (k == K_PUSH_CHAR) ? 2 :
                   (k == K_PUSH_INT) ? 3 : 5;
            if (sp + need > DEPTH) begin
               add_rsp(0, VT_NONE, ST_FULL, 1);
            end else begin
               case (k)
                  K_PUSH_BYTE: push_byte(v[7:0]);
                  K_PUSH_CHAR: begin
                     push_byte(v[7:0]); push_byte(TAG_CHAR_DEF[7:0]);
                  end
                  K_PUSH_INT: begin
                     push_byte(v[15:8]); push_byte(v[7:0]); push_byte(TAG_INT_DEF[7:0]);
                  end
                  default: begin
                     push_byte(v[31:24]); push_byte(v[23:16]);
                     push_byte(v[15:8]); push_byte(v[7:0]);
                     push_byte(TAG_FLOAT_DEF[7:0]);
                  end
               endcase
               add_rsp(0, VT_NONE, ST_OK, 1);
            end
         end
         K_POP_BYTE: begin
            if (sp == 0) begin
               add_rsp(0, VT_NONE, ST_EMPTY, 1);
            end else begin
               add_rsp({24'd0, byte_at(0)}, VT_BYTE, ST_OK, 1);
               sp--;
            end
         end
         K_PEEK_BYTE: begin
            if (off >= sp) add_rsp(0, VT_NONE, ST_EMPTY, 1);
            else add_rsp({24'd0, byte_at(off)}, VT_BYTE, ST_OK, 1);
         end
         K_POP_STR: begin
            len = (sp > 2) ? byte_at(1) : 0;
            if (sp <= 2 || byte_at(0) != TAG_STRING_DEF[7:0] || len == 0 ||
                len > MAXS || len > sp - 2) begin
               add_rsp(0, VT_NONE, ST_EMPTY, 1);
            end else begin
               for (int i = 0; i < len; i++)
                  add_rsp({24'd0, byte_at(len + 1 - i)}, VT_STRB, ST_OK, i + 1 == len);
               sp -= len + 2;
            end
         end
         default: begin
            // typed or generic read of the top value
            vt = VT_NONE;
            if (k == K_POP_ANY || k == K_PEEK_ANY) begin
               if (sp > 0) begin
                  if (byte_at(0) == TAG_CHAR_DEF[7:0]) vt = VT_CHAR;
                  else if (byte_at(0) == TAG_INT_DEF[7:0]) vt = VT_INT;
                  else if (byte_at(0) == TAG_FLOAT_DEF[7:0]) vt = VT_FLOAT;
               end
            end else if (k == K_POP_CHAR || k == K_PEEK_CHAR) vt = VT_CHAR;
            else if (k == K_POP_INT || k == K_PEEK_INT) vt = VT_INT;
            else vt = VT_FLOAT;
            need = (vt == VT_CHAR) ? 2 : (vt == VT_INT) ? 3 : 5;
            want_tag = (vt == VT_CHAR) ? TAG_CHAR_DEF[7:0] :
                       (vt == VT_INT) ? TAG_INT_DEF[7:0] : TAG_FLOAT_DEF[7:0];
            if (vt == VT_NONE || sp < need || byte_at(0) != want_tag) begin
               add_rsp(0, VT_NONE, ST_EMPTY, 1);
            end else begin
               if (vt == VT_CHAR) d = {24'd0, byte_at(1)};
               else if (vt == VT_INT) d = {16'd0, byte_at(2), byte_at(1)};
               else d = {byte_at(4), byte_at(3), byte_at(2), byte_at(1)};
               add_rsp(d, vt, ST_OK, 1);
               if (k == K_POP_CHAR || k == K_POP_INT || k == K_POP_FLOAT || k == K_POP_ANY)
                  sp -= need;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         sp = 0;
         clear_string();
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_stack(kind_type'(req_tdata[3:0]), req_tdata[35:4], req_tdata[43:36],
                          req_tdata[50:44], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[34:32], rsp_tdata[36:35], rsp_tlast};
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%t unexpected response data=%h type=%0d status=%0d last=%b",
                           $realtime, got.data, got.vtype, got.status, got.last);
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%t mismatch: expected data=%h type=%0d status=%0d last=%b, got data=%h type=%0d status=%0d last=%b",
                              $realtime, want.data, want.vtype, want.status, want.last,
                              got.data, got.vtype, got.status, got.last);
               end
            end
         end
      end
   end

endmodule

// ===== tb/tagged_byte_stack_test.sv =====
// ----------------------------------------------------------------------------
// tagged_byte_stack_test
// stimulus and verdict for the tagged byte stack
// ----------------------------------------------------------------------------
// Directed words cover each kind, field extremes and the string corner
// cases, then random typed push/pop traffic and string runs. Three idle
// phases vary the gaps on the request and response channels.
module tagged_byte_stack_test;
   import tbs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending_count;
   int          req_idle_pct;
   int          rsp_idle_pct;

   always #5 clock = ~clock;

   tagged_byte_stack u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   tagged_byte_stack_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // response side stalls at random
   always @(negedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= rsp_idle_pct);

   // one word on the request channel, with a random gap first
   task automatic send_word(kind_type k, logic [31:0] v, logic [7:0] off = 0,
                            logic [6:0] slen = 1, logic fin = 0);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {5'd0, slen, off, v, k};
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // whole string of n bytes, random content, terminator zero
   task automatic send_string(int n, logic [6:0] slen);
      for (int i = 0; i < n; i++)
         send_word(K_PUSH_STR, (i == n - 1) ? {24'd0, 8'd0} : $urandom, 8'($urandom),
                   slen, i == n - 1);
   endtask

   task automatic send_random_word();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 10) begin
         n = $urandom_range(1, 12);
         send_string(n, (n == 12) ? 7'($urandom_range(0, 127)) : 7'(n));
      end else if (pick < 45) begin
         send_word(kind_type'($urandom_range(0, 3)), $urandom, 8'($urandom));
      end else if (pick < 90) begin
         send_word(kind_type'($urandom_range(5, 15)), $urandom,
                   8'($urandom_range(0, 20)));
      end else begin
         send_word(kind_type'($urandom_range(0, 15)), $urandom, 8'($urandom),
                   7'($urandom), 1'($urandom_range(0, 1)));
      end
   endtask

   // hard stop
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      req_idle_pct = 31;
      rsp_idle_pct = 53;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // empty stack reads
      send_word(K_POP_BYTE, 0);
      send_word(K_POP_ANY, 0);
      send_word(K_PEEK_ANY, 0);
      send_word(K_POP_STR, 0);
      send_word(K_PEEK_BYTE, 0, 8'hff);
      // each non-string push kind at field extremes, read back
      send_word(K_PUSH_BYTE, 32'hffffffff);
      send_word(K_PUSH_CHAR, 32'h00000000);
      send_word(K_PUSH_INT, 32'h0000ffff);
      send_word(K_PUSH_FLOAT, 32'hffffffff);
      send_word(K_PEEK_INT, 0);
      send_word(K_PEEK_FLOAT, 0);
      send_word(K_PEEK_BYTE, 0, 8'd4);
      send_word(K_POP_FLOAT, 0);
      send_word(K_PEEK_ANY, 0);
      send_word(K_POP_INT, 0);
      send_word(K_POP_ANY, 0);
      send_word(K_POP_CHAR, 0);
      // strings: normal, bad length, interrupted, full length
      send_string(3, 3);
      send_word(K_POP_ANY, 0);
      send_word(K_POP_STR, 0);
      send_string(2, 0);
      send_string(2, 7'd127);
      send_word(K_PUSH_STR, 32'h41, 0, 5, 0);
      send_word(K_PEEK_CHAR, 0);
      send_string(64, 64);
      send_word(K_POP_STR, 0);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 53 : 0;
         rsp_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 31 : 0;
         for (int i = 0; i < 40; i++) send_random_word();
         if (phase == 1) begin
            // fill toward the top to hit full refusals and overlong strings
            for (int i = 0; i < 52; i++) send_word(K_PUSH_FLOAT, $urandom);
            send_string(10, 10);
            send_word(K_PUSH_BYTE, $urandom);
            send_word(K_PUSH_INT, $urandom);
            send_word(K_POP_ANY, 0);
            for (int i = 0; i < 52; i++) send_word(K_POP_ANY, 0);
         end
      end
      req_tvalid <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
